### design/piecewise_linear_colormap_defines.svh
// Assertion macros shared by the colormap RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PIECEWISE_LINEAR_COLORMAP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLORMAP_DEFINES_SVH

// same-cycle implication
`define PLC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/plc_pkg.sv
// Shared constants and types for the piecewise linear colormap.
// No dependencies.
package plc_pkg;

	localparam int MAX_STOPS  = 8;
	localparam int LEVEL_BITS = 16;
	localparam int NUM_REGS   = 8;
	localparam int POS_W      = 16;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int COLOR_W    = CH_W * NUM_CH;
	localparam int REG_W      = 41;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 6;
	localparam int IDX_W      = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int CNT_W      = $clog2(MAX_STOPS + 1);
	localparam int NUM_W      = POS_W + CH_W;
	localparam int Q_BITS     = CH_W;

	localparam logic [POS_W-1:0] LEVEL_MASK = POS_W'((64'h1 << LEVEL_BITS) - 64'h1);

	typedef enum logic [1:0] {
		MODE_BLACK,
		MODE_COLOR,
		MODE_INTERP
	} mode_t;

	// color that bypasses the divider
	typedef struct packed {
		logic               bypass;
		logic [COLOR_W-1:0] color;
	} side_t;

endpackage

### design/piecewise_linear_colormap.sv
// Piecewise linear colormap: level in, RGB out, up to eight stops over APB.
// Depends on plc_pkg, plc_div and piecewise_linear_colormap_defines.svh.
//
// One level in per cycle unless stalled, one color out per level, in order.
// Four stages do stop search, operand fetch, the channel multiplies and
// the numerator sum, then eight stages of a pipelined divider give one
// quotient bit each. The whole pipeline holds while a finished color is
// stalled, so level_stall follows color_stall when the output is full.
// Stops must be written only while idle; the block does not enforce it.
`include "piecewise_linear_colormap_defines.svh"

module piecewise_linear_colormap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [plc_pkg::ADDR_W-1:0]  paddr,
	input  logic [plc_pkg::DATA_W-1:0]  pwdata,
	output logic [plc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        level_valid,
	output logic                        level_stall,
	input  logic [15:0]                 level,
	output logic                        color_valid,
	input  logic                        color_stall,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue
);

	localparam int PW = plc_pkg::POS_W;
	localparam int CW = plc_pkg::CH_W;
	localparam int NC = plc_pkg::NUM_CH;
	localparam int NW = plc_pkg::NUM_W;

	logic [plc_pkg::REG_W-1:0] stop_q [plc_pkg::NUM_REGS];
	logic                      en;

	// ---- configuration port
	assign pready = 1'b1;
	assign prdata = plc_pkg::DATA_W'(stop_q[paddr[plc_pkg::ADDR_W-1:3]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < plc_pkg::NUM_REGS; i++) stop_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			stop_q[paddr[plc_pkg::ADDR_W-1:3]] <= pwdata[plc_pkg::REG_W-1:0];
		end
	end

	function automatic logic [PW-1:0] pos_of(input logic [plc_pkg::REG_W-1:0] r);
		return r[39:24];
	endfunction

	assign en          = !(color_valid && color_stall);
	assign level_stall = !en;

	// ---- stage 1: leading valid run and bracket search
	logic [PW-1:0]             v_in;
	logic [plc_pkg::CNT_W-1:0] cnt;
	logic [PW-1:0]             last_pos;
	logic [plc_pkg::IDX_W-1:0] b_idx;
	plc_pkg::mode_t            mode_d;
	logic [plc_pkg::IDX_W-1:0] a_d;

	assign v_in = level & plc_pkg::LEVEL_MASK;

	always_comb begin
		logic run;
		logic found;
		run      = 1'b1;
		found    = 1'b0;
		cnt      = '0;
		last_pos = '0;
		b_idx    = '0;
		for (int i = 0; i < plc_pkg::MAX_STOPS; i++) begin
			if (run && stop_q[i][40]) cnt = plc_pkg::CNT_W'(i + 1);
			else run = 1'b0;
		end
		for (int i = 0; i < plc_pkg::MAX_STOPS; i++) begin
			if (i + 1 == int'(cnt)) begin
				last_pos = pos_of(stop_q[i]);
				b_idx    = plc_pkg::IDX_W'(i);
			end
		end
		for (int j = 1; j < plc_pkg::MAX_STOPS; j++) begin
			if (!found && (j + 1 < int'(cnt)) && (pos_of(stop_q[j]) >= v_in)) begin
				b_idx = plc_pkg::IDX_W'(j);
				found = 1'b1;
			end
		end
		mode_d = plc_pkg::MODE_INTERP;
		a_d    = b_idx - plc_pkg::IDX_W'(1);
		if (cnt == '0) begin
			mode_d = plc_pkg::MODE_BLACK;
			a_d    = '0;
		end else if (cnt == plc_pkg::CNT_W'(1)) begin
			mode_d = plc_pkg::MODE_COLOR;
			a_d    = '0;
		end else if (v_in > last_pos) begin
			mode_d = plc_pkg::MODE_COLOR;
			a_d    = plc_pkg::IDX_W'(int'(cnt) - 1);
		end else if (v_in < pos_of(stop_q[0])) begin
			mode_d = plc_pkg::MODE_COLOR;
			a_d    = '0;
		end
	end

	logic                      valid_s1;
	logic [PW-1:0]             v_s1;
	plc_pkg::mode_t            mode_s1;
	logic [plc_pkg::IDX_W-1:0] a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= level_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= v_in;
			mode_s1 <= mode_d;
			a_s1    <= a_d;
		end
	end

	// ---- stage 2: fetch stop pair, degenerate bracket check, differences
	logic [plc_pkg::REG_W-1:0] ra, rb;
	logic [PW-1:0]             pa, pb;
	plc_pkg::side_t            side_d2;

	assign ra = stop_q[a_s1];
	assign rb = stop_q[a_s1 + plc_pkg::IDX_W'(1)];
	assign pa = pos_of(ra);
	assign pb = pos_of(rb);

	always_comb begin
		side_d2.bypass = 1'b1;
		side_d2.color  = ra[plc_pkg::COLOR_W-1:0];
		case (mode_s1)
			plc_pkg::MODE_BLACK:  side_d2.color = '0;
			plc_pkg::MODE_COLOR:  side_d2.bypass = 1'b1;
			plc_pkg::MODE_INTERP:
				side_d2.bypass = (pb <= pa) || (v_s1 < pa) || (v_s1 > pb);
			default:              side_d2.color = '0;
		endcase
	end

	logic                           valid_s2;
	plc_pkg::side_t                 side_s2;
	logic [PW-1:0]                  dhi_s2, dlo_s2, span_s2;
	logic [plc_pkg::COLOR_W-1:0]    ca_s2, cb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_d2;
			dhi_s2  <= pb - v_s1;
			dlo_s2  <= v_s1 - pa;
			span_s2 <= pb - pa;
			ca_s2   <= ra[plc_pkg::COLOR_W-1:0];
			cb_s2   <= rb[plc_pkg::COLOR_W-1:0];
		end
	end

	// ---- stage 3: weight products; channel 0 is red (top byte)
	logic                      valid_s3;
	plc_pkg::side_t            side_s3;
	logic [PW-1:0]             span_s3;
	logic [NC-1:0][NW-1:0]     phi_s3, plo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			span_s3 <= span_s2;
			for (int c = 0; c < NC; c++) begin
				phi_s3[c] <= NW'(dhi_s2) * NW'(ca_s2[(NC-1-c)*CW +: CW]);
				plo_s3[c] <= NW'(dlo_s2) * NW'(cb_s2[(NC-1-c)*CW +: CW]);
			end
		end
	end

	// ---- stage 4: numerator with half-span rounding term
	logic                  valid_s4;
	plc_pkg::side_t        side_s4;
	logic [PW-1:0]         span_s4;
	logic [NC-1:0][NW-1:0] num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (en) valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			span_s4 <= span_s3;
			for (int c = 0; c < NC; c++)
				num_s4[c] <= phi_s3[c] + plo_s3[c] + NW'(span_s3 >> 1);
		end
	end

	// ---- stages 5..12: divider
	logic                  div_vld;
	logic [NC-1:0][CW-1:0] quo;
	plc_pkg::side_t        side_out;

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (valid_s4),
		.num      (num_s4),
		.span     (span_s4),
		.side_in  (side_s4),
		.out_vld  (div_vld),
		.quo      (quo),
		.side_out (side_out)
	);

	assign color_valid = div_vld;
	assign red   = side_out.bypass ? side_out.color[23:16] : quo[0];
	assign green = side_out.bypass ? side_out.color[15:8]  : quo[1];
	assign blue  = side_out.bypass ? side_out.color[7:0]   : quo[2];

	`PLC_ASSERT_IMP(a_span_nonzero, valid_s2 && !side_s2.bypass, span_s2 != '0, "interpolating over zero span")
	`PLC_ASSERT_NXT(a_freeze_s1, color_valid && color_stall, $stable(valid_s1) && $stable(v_s1), "stage 1 moved during output stall")
	`PLC_ASSERT_IMP(a_black_bypass, valid_s1 && (mode_s1 == plc_pkg::MODE_BLACK), side_d2.bypass && (side_d2.color == '0), "black mode not bypassed as zero")

endmodule

### design/plc_div.sv
// Pipelined restoring divider, three channels, one quotient bit per stage.
// Depends on plc_pkg and piecewise_linear_colormap_defines.svh.
`include "piecewise_linear_colormap_defines.svh"

module plc_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_vld,
	input  logic [plc_pkg::NUM_CH-1:0][plc_pkg::NUM_W-1:0] num,
	input  logic [plc_pkg::POS_W-1:0]                 span,
	input  plc_pkg::side_t                            side_in,
	output logic                                      out_vld,
	output logic [plc_pkg::NUM_CH-1:0][plc_pkg::CH_W-1:0]  quo,
	output plc_pkg::side_t                            side_out
);

	localparam int NS = plc_pkg::Q_BITS;

	logic                                                   vld_q  [NS+1];
	logic [plc_pkg::NUM_CH-1:0][plc_pkg::NUM_W-1:0]         rem_q  [NS+1];
	logic [plc_pkg::NUM_CH-1:0][plc_pkg::CH_W-1:0]          quo_q  [NS+1];
	logic [plc_pkg::POS_W-1:0]                              span_q [NS+1];
	plc_pkg::side_t                                         side_q [NS+1];

	assign vld_q[0]  = in_vld;
	assign rem_q[0]  = num;
	assign quo_q[0]  = '0;
	assign span_q[0] = span;
	assign side_q[0] = side_in;

	for (genvar s = 0; s < NS; s++) begin : g_stage
		localparam int K = NS - 1 - s;
		logic [plc_pkg::NUM_W-1:0]                     dsh;
		logic [plc_pkg::NUM_CH-1:0][plc_pkg::NUM_W-1:0] rem_d;
		logic [plc_pkg::NUM_CH-1:0][plc_pkg::CH_W-1:0]  quo_d;

		assign dsh = plc_pkg::NUM_W'(span_q[s]) << K;

		always_comb begin
			rem_d = rem_q[s];
			quo_d = quo_q[s];
			for (int c = 0; c < plc_pkg::NUM_CH; c++) begin
				if (rem_q[s][c] >= dsh) begin
					rem_d[c]    = rem_q[s][c] - dsh;
					quo_d[c][K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s+1] <= 1'b0;
			end else if (en) begin
				vld_q[s+1] <= vld_q[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s+1]  <= rem_d;
				quo_q[s+1]  <= quo_d;
				span_q[s+1] <= span_q[s];
				side_q[s+1] <= side_q[s];
			end
		end
	end

	assign out_vld  = vld_q[NS];
	assign quo      = quo_q[NS];
	assign side_out = side_q[NS];

	`PLC_ASSERT_IMP(a_rem_below_span, vld_q[NS] && !side_q[NS].bypass, (rem_q[NS][0] < plc_pkg::NUM_W'(span_q[NS])) && (rem_q[NS][2] < plc_pkg::NUM_W'(span_q[NS])), "divider remainder not below divisor")

endmodule
